// ===== hw/rtl/fpm_pkg.sv =====
// ----------------------------------------------------------------------------
// fpm_pkg
// Shared widths, constants, types and helpers for the frame pacer and
// frame-rate meter.
// ----------------------------------------------------------------------------
package fpm_pkg;

    // field widths
    localparam int DUR_W      = 20;
    localparam int STEP_W     = 20;
    localparam int CATCH_W    = 4;
    localparam int OUT_W      = 24;
    localparam int FILL_OUT_W = 7;
    localparam int LAG_W      = 32;
    localparam int SUM_W      = 26;
    localparam int FRAC_BITS  = 16;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    // shared divider
    localparam int DIV_N_W    = 48;
    localparam int DIV_D_W    = 26;

    // ring depth
    localparam int WINDOW_DEF = 64;

    // constants
    localparam logic [DUR_W-1:0]   DUR_LIMIT   = 20'd1000000;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 20'd16667;
    localparam logic [CATCH_W-1:0] CATCH_RESET = 4'd5;
    localparam logic [OUT_W-1:0]   OUT_MAX     = {OUT_W{1'b1}};

    // one million microseconds per second times 256 for the Q.8 result
    localparam int                       FPS_SCALE_W = 28;
    localparam logic [FPS_SCALE_W-1:0]   FPS_SCALE   = 28'd256000000;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_LENGTH  = 1'b0,
        CFG_MAX_CATCH_UP = 1'b1
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CATCH,
        S_RING,
        S_DIV_INT,
        S_MUL,
        S_FPS_GO,
        S_DIV_FPS,
        S_DONE
    } t_state;

    // divider request and response
    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quot;
    } t_div_rsp;

    // saturate a quotient to the 24-bit result range
    function automatic logic [OUT_W-1:0] sat_out(input logic [DIV_N_W-1:0] q);
        logic [OUT_W-1:0] res;
        if (|q[DIV_N_W-1:OUT_W]) begin
            res = OUT_MAX;
        end else begin
            res = q[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/fpm_ram.sv =====
// ----------------------------------------------------------------------------
// fpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fpm_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/fpm_div.sv =====
// ----------------------------------------------------------------------------
// fpm_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fpm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fpm_pkg::t_div_req i_req,
    output fpm_pkg::t_div_rsp o_rsp
);
    import fpm_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [DIV_N_W-1:0] r_num, n_num;
    logic [DIV_N_W-1:0] r_quo, n_quo;
    logic [DIV_D_W-1:0] r_rem, n_rem;
    logic [DIV_D_W-1:0] r_den, n_den;
    logic [DIV_D_W:0]   trial;

    // one compare and subtract per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        trial  = {r_rem, r_num[DIV_N_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIV_N_W);
            n_num  = i_req.num;
            n_den  = i_req.den;
            n_rem  = '0;
            n_quo  = '0;
        end else if (r_busy) begin
            n_num = {r_num[DIV_N_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                n_rem = DIV_D_W'(trial - {1'b0, r_den});
                n_quo = {r_quo[DIV_N_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DIV_D_W-1:0];
                n_quo = {r_quo[DIV_N_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

// ===== hw/rtl/frame_pacer_fps_meter.sv =====
// ----------------------------------------------------------------------------
// frame_pacer_fps_meter
// Fixed-timestep frame pacer with a moving-average frame-rate meter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one measured frame duration in
//   microseconds per beat. Output channel (o_valid / i_ready) returns one
//   beat per input: catch-up update count, behind flag, Q8.16 interpolation
//   fraction, Q16.8 average frame rate and the number of frames averaged.
//   Config writes (i_cfg_we) set the step length and the catch-up limit.
// Sequence:
//   One frame at a time: catch-up runs one update per cycle (0 to 15), then
//   a ring update, a run of the shared divider, a multiply, a divide launch,
//   a second divider run and an output hand-over. The second run is skipped
//   when the window sum is zero. The next frame can be taken from the cycle
//   in which o_valid rises.
// Reset:
//   Registers return to their defaults and the lag accumulator, ring fill
//   count, write slot and sum clear. The ring RAM is not swept: entries not
//   yet written read as zero through the fill count.
// Stall:
//   A finished beat waits in the output register; o_ready returns once the
//   sequencer is idle, so a new frame can be taken while a beat waits.
// ----------------------------------------------------------------------------
module frame_pacer_fps_meter #(
    parameter int WINDOW = fpm_pkg::WINDOW_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // frame duration input
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [fpm_pkg::DUR_W-1:0]        i_frame_duration_us,
    // pacing result output
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [fpm_pkg::CATCH_W-1:0]      o_updates_to_run,
    output logic                             o_still_behind,
    output logic [fpm_pkg::OUT_W-1:0]        o_interpolation_q16,
    output logic [fpm_pkg::OUT_W-1:0]        o_fps_q8,
    output logic [fpm_pkg::FILL_OUT_W-1:0]   o_frames_in_window,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [fpm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fpm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fpm_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int PROD_W = FILL_W + FPS_SCALE_W;

    t_state r_state, n_state;

    // configuration
    logic [STEP_W-1:0]  r_step;
    logic [CATCH_W-1:0] r_max_catch;
    logic [STEP_W-1:0]  step_eff;

    // working state
    logic [DUR_W-1:0]   r_dur, n_dur;
    logic [LAG_W-1:0]   r_lag, n_lag;
    logic [CATCH_W-1:0] r_loops, n_loops;
    logic               r_behind, n_behind;
    logic [OUT_W-1:0]   r_interp, n_interp;
    logic [OUT_W-1:0]   r_fps, n_fps;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [FILL_W-1:0]  r_filled, n_filled;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [CATCH_W-1:0]    r_o_updates;
    logic                  r_o_behind;
    logic [OUT_W-1:0]      r_o_interp;
    logic [OUT_W-1:0]      r_o_fps;
    logic [FILL_OUT_W-1:0] r_o_frames;
    logic                  load_out;

    // datapath helpers
    logic [DUR_W-1:0] dur_clamp;
    logic [LAG_W:0]   lag_add;
    logic [DUR_W-1:0] ring_rdata;
    logic [DUR_W-1:0] old_dur;
    logic             ring_we;
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    assign step_eff  = (r_step == '0) ? STEP_W'(1) : r_step;
    assign dur_clamp = (i_frame_duration_us > DUR_LIMIT) ? DUR_LIMIT : i_frame_duration_us;
    assign lag_add   = {1'b0, r_lag} + (LAG_W + 1)'(dur_clamp);
    assign old_dur   = (r_filled == FILL_W'(WINDOW)) ? ring_rdata : '0;

    // duration ring
    fpm_ram #(
        .WIDTH (DUR_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_slot),
        .i_wdata (r_dur),
        .i_raddr (r_slot),
        .o_rdata (ring_rdata)
    );

    // shared divider
    fpm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_RESET;
            r_max_catch <= CATCH_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_STEP_LENGTH:  r_step      <= i_cfg_data[STEP_W-1:0];
                CFG_MAX_CATCH_UP: r_max_catch <= i_cfg_data[CATCH_W-1:0];
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer: next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_dur       = r_dur;
        n_lag       = r_lag;
        n_loops     = r_loops;
        n_behind    = r_behind;
        n_interp    = r_interp;
        n_fps       = r_fps;
        n_prod      = r_prod;
        n_sum       = r_sum;
        n_slot      = r_slot;
        n_filled    = r_filled;
        n_out_valid = r_out_valid;
        load_out    = 1'b0;
        ring_we     = 1'b0;
        div_req     = '0;
        o_ready     = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_dur   = dur_clamp;
                    n_lag   = lag_add[LAG_W] ? {LAG_W{1'b1}} : lag_add[LAG_W-1:0];
                    n_loops = '0;
                    n_state = S_CATCH;
                end
            end
            S_CATCH: begin
                // one step length off per cycle
                if ((r_lag >= LAG_W'(step_eff)) && (r_loops < r_max_catch)) begin
                    n_lag   = r_lag - LAG_W'(step_eff);
                    n_loops = r_loops + CATCH_W'(1);
                end else begin
                    n_state = S_RING;
                end
            end
            S_RING: begin
                // ring write, running sum, and start of the fraction divide
                n_behind = (r_lag >= LAG_W'(step_eff));
                n_sum    = r_sum - SUM_W'(old_dur) + SUM_W'(r_dur);
                ring_we  = 1'b1;
                n_slot   = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + SLOT_W'(1);
                if (r_filled != FILL_W'(WINDOW)) begin
                    n_filled = r_filled + FILL_W'(1);
                end
                div_req.start = 1'b1;
                div_req.num   = {r_lag, {FRAC_BITS{1'b0}}};
                div_req.den   = DIV_D_W'(step_eff);
                n_state = S_DIV_INT;
            end
            S_DIV_INT: begin
                if (div_rsp.done) begin
                    n_interp = sat_out(div_rsp.quot);
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_filled) * PROD_W'(FPS_SCALE);
                n_state = S_FPS_GO;
            end
            S_FPS_GO: begin
                if (r_sum == '0) begin
                    n_fps   = OUT_MAX;
                    n_state = S_DONE;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_N_W'(r_prod);
                    div_req.den   = DIV_D_W'(r_sum);
                    n_state = S_DIV_FPS;
                end
            end
            S_DIV_FPS: begin
                if (div_rsp.done) begin
                    n_fps   = sat_out(div_rsp.quot);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hand over once the output register is free
                if (!r_out_valid || i_ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lag       <= '0;
            r_sum       <= '0;
            r_slot      <= '0;
            r_filled    <= '0;
            r_loops     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_lag       <= n_lag;
            r_sum       <= n_sum;
            r_slot      <= n_slot;
            r_filled    <= n_filled;
            r_loops     <= n_loops;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_dur    <= n_dur;
        r_behind <= n_behind;
        r_interp <= n_interp;
        r_fps    <= n_fps;
        r_prod   <= n_prod;
        if (load_out) begin
            r_o_updates <= r_loops;
            r_o_behind  <= r_behind;
            r_o_interp  <= r_interp;
            r_o_fps     <= r_fps;
            r_o_frames  <= FILL_OUT_W'(r_filled);
        end
    end

    assign o_valid             = r_out_valid;
    assign o_updates_to_run    = r_o_updates;
    assign o_still_behind      = r_o_behind;
    assign o_interpolation_q16 = r_o_interp;
    assign o_fps_q8            = r_o_fps;
    assign o_frames_in_window  = r_o_frames;

endmodule

// ===== hw/rtl/fpm_checker.sv =====
// ----------------------------------------------------------------------------
// fpm_checker
// Port-level checks for the frame pacer, bound to the top level.
// ----------------------------------------------------------------------------
module fpm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_ready,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic [fpm_pkg::CATCH_W-1:0]      o_updates_to_run,
    input logic                             o_still_behind,
    input logic [fpm_pkg::OUT_W-1:0]        o_interpolation_q16,
    input logic [fpm_pkg::OUT_W-1:0]        o_fps_q8,
    input logic [fpm_pkg::FILL_OUT_W-1:0]   o_frames_in_window
);
    import fpm_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_updates_to_run)
            && $stable(o_still_behind) && $stable(o_interpolation_q16)
            && $stable(o_fps_q8) && $stable(o_frames_in_window))
        else $error("result beat changed while stalled");

    // one frame at a time: busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken while a frame is in work");

    // every result covers at least the frame it answers, at most the ring
    a_frames_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frames_in_window != '0)
            && (o_frames_in_window <= FILL_OUT_W'(WINDOW_DEF)))
        else $error("frame count out of range");

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind frame_pacer_fps_meter fpm_checker u_fpm_checker (.*);
